>>> rtl/asrl_pkg.sv
// Shared types and constants for the ADC scan rate limit evaluator.
// No dependencies; used by every module under rtl/.
package asrl_pkg;

    // Register file layout.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_CLK_DIV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_DIV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE  = 2'd2;

    localparam int CLK_DIV_W = 6;
    localparam int ADC_DIV_W = 7;
    localparam int SAMPLE_W  = 10;
    localparam int COUNT_W   = 7;
    localparam int RATE_W    = 32;

    localparam logic [CLK_DIV_W-1:0] CLK_DIV_RST = 6'd4;
    localparam logic [ADC_DIV_W-1:0] ADC_DIV_RST = 7'd1;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_RST  = 10'd100;

    // Arithmetic constants.
    localparam logic [SAMPLE_W:0] PER_INPUT_EXTRA = 11'd16;
    // Period = 11/10 x (20 x P + 6000) = 22 x P + 6600, exact in integers.
    localparam logic [12:0] FIXED_PERIOD_NS = 13'd6600;
    // 22 x P + 6600 <= 96144 (rate above the cap) exactly when P <= 4070.
    localparam logic [30:0] CAP_PRODUCT_MAX = 31'd4070;
    localparam logic [RATE_W-1:0] RATE_CAP_HZ = 32'd10400;
    localparam logic [RATE_W-1:0] RATE_FLOOR_HZ = 32'd1;
    localparam logic [RATE_W-1:0] NO_BOUND = 32'hFFFF_FFFF;

    // Long division of one second in ns by the period, one quotient bit per cell.
    localparam int QUOT_W = 14;
    localparam int NUM_W  = 30;
    localparam logic [NUM_W-1:0] NS_PER_SECOND = 30'd1000000000;
    localparam int DIV_W  = 36;
    localparam int PROD_W = 31;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic              cap;
        logic [DIV_W-1:0]  rem;
        logic [DIV_W-1:0]  divisor;
        logic [QUOT_W-1:0] low;
        logic [QUOT_W-1:0] quot;
    } t_div_stage;

    typedef struct packed {
        logic [CLK_DIV_W-1:0] clk_div;
        logic [ADC_DIV_W-1:0] adc_div;
        logic [SAMPLE_W-1:0]  sample;
    } t_cfg;

endpackage

>>> rtl/asrl_front.sv
// Front pipeline of the scan rate limit evaluator: forms the scan period in ns.
// Depends on asrl_pkg.
module asrl_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [asrl_pkg::COUNT_W-1:0]  i_count,
    input  asrl_pkg::t_cfg                i_cfg,
    output asrl_pkg::t_div_stage          o_stage
);

    localparam int QW = asrl_pkg::QUOT_W;

    logic                            r_s1_valid, r_s1_zero;
    logic [asrl_pkg::COUNT_W-1:0]    r_s1_count;
    logic [asrl_pkg::SAMPLE_W:0]     r_s1_sample16;
    logic [asrl_pkg::ADC_DIV_W-1:0]  r_s1_div;
    logic [asrl_pkg::CLK_DIV_W:0]    r_s1_clkp1;

    logic        r_s2_valid, r_s2_zero;
    logic [17:0] r_s2_m1;
    logic [12:0] r_s2_t1;

    logic                          r_s3_valid, r_s3_zero;
    logic [asrl_pkg::PROD_W-1:0]   r_s3_p;

    asrl_pkg::t_div_stage r_s4_stage, n_s4_stage;
    logic [asrl_pkg::DIV_W-1:0] n_p_wide;

    always_comb begin
        n_p_wide = {{(asrl_pkg::DIV_W-asrl_pkg::PROD_W){1'b0}}, r_s3_p};
        n_s4_stage.valid   = r_s3_valid;
        n_s4_stage.zero    = r_s3_zero;
        n_s4_stage.cap     = (r_s3_p <= asrl_pkg::CAP_PRODUCT_MAX);
        n_s4_stage.divisor = (n_p_wide << 4) + (n_p_wide << 2) + (n_p_wide << 1)
                             + {{(asrl_pkg::DIV_W-13){1'b0}}, asrl_pkg::FIXED_PERIOD_NS};
        // The quotient is known to fit in QUOT_W bits once the cap case is set aside.
        n_s4_stage.rem     = {{(asrl_pkg::DIV_W-(asrl_pkg::NUM_W-QW)){1'b0}},
                              asrl_pkg::NS_PER_SECOND[asrl_pkg::NUM_W-1:QW]};
        n_s4_stage.low     = asrl_pkg::NS_PER_SECOND[QW-1:0];
        n_s4_stage.quot    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid       <= 1'b0;
            r_s2_valid       <= 1'b0;
            r_s3_valid       <= 1'b0;
            r_s4_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid    <= i_valid;
            r_s1_zero     <= (i_count == '0);
            r_s1_count    <= i_count;
            r_s1_sample16 <= {1'b0, i_cfg.sample} + asrl_pkg::PER_INPUT_EXTRA;
            r_s1_div      <= (i_cfg.adc_div == '0) ? asrl_pkg::ADC_DIV_W'(1) : i_cfg.adc_div;
            r_s1_clkp1    <= {1'b0, i_cfg.clk_div} + (asrl_pkg::CLK_DIV_W+1)'(1);

            r_s2_valid <= r_s1_valid;
            r_s2_zero  <= r_s1_zero;
            r_s2_m1    <= 18'(r_s1_count * r_s1_sample16);
            r_s2_t1    <= 13'(r_s1_div * r_s1_clkp1);

            r_s3_valid <= r_s2_valid;
            r_s3_zero  <= r_s2_zero;
            r_s3_p     <= asrl_pkg::PROD_W'(r_s2_m1 * r_s2_t1);

            r_s4_stage <= n_s4_stage;
        end
    end

    assign o_stage = r_s4_stage;

endmodule

>>> rtl/asrl_div_cell.sv
// One restoring-division cell: produces one quotient bit and hands on the remainder.
// Depends on asrl_pkg.
module asrl_div_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  asrl_pkg::t_div_stage  i_stage,
    output asrl_pkg::t_div_stage  o_stage
);

    localparam int DW = asrl_pkg::DIV_W;
    localparam int QW = asrl_pkg::QUOT_W;

    asrl_pkg::t_div_stage r_stage, n_stage;
    logic [DW:0] n_shifted;
    logic        n_fits;

    always_comb begin
        n_shifted = {i_stage.rem, i_stage.low[QW-1]};
        n_fits    = (n_shifted >= {1'b0, i_stage.divisor});
        n_stage       = i_stage;
        n_stage.rem   = n_fits ? DW'(n_shifted - {1'b0, i_stage.divisor})
                               : n_shifted[DW-1:0];
        n_stage.low   = {i_stage.low[QW-2:0], 1'b0};
        n_stage.quot  = {i_stage.quot[QW-2:0], n_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> rtl/adc_scan_rate_limit.sv
// ADC scan rate limit evaluator, top level.
// Depends on asrl_pkg, asrl_front and asrl_div_cell.

// Each input beat carries the number of inputs in a scan list, and the block
// answers with the highest scan trigger rate in hertz at which the scan can
// never be retriggered while still busy. The conversion clock period is
// 20 x adc_div x (clk_div + 1) ns, the busy time is count x (sample + 16)
// periods plus 6000 ns, and a 10% margin is added before one second is
// divided by the result; the rate is held to 1 .. 10400, and a count of zero
// answers all ones (no bound). The block accepts one beat per clock while the
// output is not stalled and returns results in order through the input
// register, the two multiplier stages, the register that forms the scan
// period, fourteen division cells that each settle one quotient bit, and
// the output register. The whole pipeline advances together whenever the
// output register is empty or being read, so a stalled result holds every
// stage in place. The three timing registers are written through the plain
// write port and are sampled by each beat as it enters.
module adc_scan_rate_limit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [asrl_pkg::COUNT_W-1:0]    i_active_count,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [asrl_pkg::RATE_W-1:0]     o_max_rate_hz,

    input  logic                            i_cfg_we,
    input  logic [asrl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [asrl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NCELL = asrl_pkg::QUOT_W;

    asrl_pkg::t_cfg r_cfg;
    logic           w_en;

    // Stage array: entry 0 comes from the front, entry k from division cell k-1.
    asrl_pkg::t_div_stage w_stage [NCELL+1];

    logic                         r_out_valid;
    logic [asrl_pkg::RATE_W-1:0]  r_rate, n_rate;
    asrl_pkg::t_div_stage         w_last;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clk_div <= asrl_pkg::CLK_DIV_RST;
            r_cfg.adc_div <= asrl_pkg::ADC_DIV_RST;
            r_cfg.sample  <= asrl_pkg::SAMPLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                asrl_pkg::CFG_CLK_DIV: r_cfg.clk_div <= i_cfg_data[asrl_pkg::CLK_DIV_W-1:0];
                asrl_pkg::CFG_ADC_DIV: r_cfg.adc_div <= i_cfg_data[asrl_pkg::ADC_DIV_W-1:0];
                asrl_pkg::CFG_SAMPLE:  r_cfg.sample  <= i_cfg_data[asrl_pkg::SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves when the output register is free or being drained.
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    asrl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_count (i_active_count),
        .i_cfg   (r_cfg),
        .o_stage (w_stage[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        asrl_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    assign w_last = w_stage[NCELL];

    // Final selection: no scan armed, rate above the cap, a quotient of zero, or else the quotient itself.
    always_comb begin
        if (w_last.zero) begin
            n_rate = asrl_pkg::NO_BOUND;
        end else if (w_last.cap) begin
            n_rate = asrl_pkg::RATE_CAP_HZ;
        end else if (w_last.quot == '0) begin
            n_rate = asrl_pkg::RATE_FLOOR_HZ;
        end else begin
            n_rate = {{(asrl_pkg::RATE_W-NCELL){1'b0}}, w_last.quot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
            r_rate      <= n_rate;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_max_rate_hz = r_rate;

`ifndef SYNTHESIS
    // A delivered rate is either the no-bound code or within 1 .. 10400.
    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_max_rate_hz == asrl_pkg::NO_BOUND) ||
                        ((o_max_rate_hz >= asrl_pkg::RATE_FLOOR_HZ) &&
                         (o_max_rate_hz <= asrl_pkg::RATE_CAP_HZ)))
        else $error("rate outside the legal range");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A finished division moves into the output register when the pipeline advances.
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_last.valid) |=> o_out_valid)
        else $error("result lost between the last cell and the output");

    // A stalled output holds the whole pipeline, including the last cell.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(w_last.valid))
        else $error("pipeline moved during an output stall");
`endif

endmodule

>>> dv/rate_limit_checker.sv
// Checker for the ADC scan rate limit evaluator: it tracks the timing registers
// from the write port, predicts the rate for each accepted beat and compares
// results in order. Depends on asrl_pkg.
`timescale 1ns / 100ps

module rate_limit_checker
    import asrl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [COUNT_W-1:0]    i_active_count,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [RATE_W-1:0]     i_max_rate_hz,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_outstanding
);

    localparam int              REPORT_LIMIT  = 10;
    localparam longint unsigned SYS_CLOCK_NS  = 10;
    localparam longint unsigned EXTRA_TADS    = 16;
    localparam longint unsigned FIXED_BUSY_NS = 6000;
    localparam longint unsigned MARGIN_NUM    = 11;
    localparam longint unsigned MARGIN_DEN    = 10;
    localparam longint unsigned ONE_SECOND_NS = 64'd1000000000;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [RATE_W-1:0]  rate_hz;
    } t_rate_expect;

    logic [CLK_DIV_W-1:0] clk_div_q;
    logic [ADC_DIV_W-1:0] adc_div_q;
    logic [SAMPLE_W-1:0]  sample_q;
    t_rate_expect         expected_rates[$];
    int                   errors;

    // Rate bound for a scan of the given length under the current timing.
    function automatic logic [RATE_W-1:0] predict_rate_hz(input logic [COUNT_W-1:0] count);
        longint unsigned adc_div;
        longint unsigned tad_ns;
        longint unsigned busy_ns;
        longint unsigned period_ns;
        longint unsigned rate;
        if (count == '0)
            return NO_BOUND;
        adc_div = (adc_div_q == '0) ? 64'd1 : longint'(adc_div_q);
        tad_ns = 64'd2 * adc_div * (longint'(clk_div_q) + 64'd1) * SYS_CLOCK_NS;
        busy_ns = longint'(count) * (longint'(sample_q) + EXTRA_TADS) * tad_ns
                  + FIXED_BUSY_NS;
        period_ns = busy_ns * MARGIN_NUM / MARGIN_DEN;
        rate = ONE_SECOND_NS / period_ns;
        if (rate > longint'(RATE_CAP_HZ))
            rate = longint'(RATE_CAP_HZ);
        if (rate == 0)
            rate = longint'(RATE_FLOOR_HZ);
        return RATE_W'(rate);
    endfunction

    task automatic log_error(input string what, input t_rate_expect want);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%0t: %s: count %0d expected %0d got %0d",
                     $time, what, want.count, want.rate_hz, i_max_rate_hz);
    endtask

    always @(posedge i_clk) begin : monitor
        t_rate_expect want;
        if (!i_rst_n) begin
            clk_div_q = CLK_DIV_RST;
            adc_div_q = ADC_DIV_RST;
            sample_q  = SAMPLE_RST;
            expected_rates.delete();
            errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_rates.size() == 0) begin
                    want = '0;
                    log_error("unexpected result beat", want);
                end else begin
                    want = expected_rates.pop_front();
                    if (i_max_rate_hz !== want.rate_hz)
                        log_error("max_rate_hz mismatch", want);
                end
            end
            // A beat samples the registers as they stand before this edge.
            if (i_in_valid && i_in_ready) begin
                want.count   = i_active_count;
                want.rate_hz = predict_rate_hz(i_active_count);
                expected_rates.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLK_DIV: clk_div_q = i_cfg_data[CLK_DIV_W-1:0];
                    CFG_ADC_DIV: adc_div_q = i_cfg_data[ADC_DIV_W-1:0];
                    CFG_SAMPLE:  sample_q  = i_cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_errors      <= errors;
        o_outstanding <= expected_rates.size();
    end

endmodule

>>> dv/testbench.sv
// Top of the testbench for adc_scan_rate_limit: clock, reset, stimulus, timing
// register programming, output stalls and the verdict. Depends on asrl_pkg,
// the block under test and rate_limit_checker.
`timescale 1ns / 100ps

module testbench;
    import asrl_pkg::*;

    localparam int CLK_HALF_NS      = 10;
    localparam int RESET_CYCLES     = 3;
    // The tail wait after every result is back is reckoned from the pipeline latency.
    localparam int PIPE_LATENCY     = 19;
    // Longest expected quiet stretch is the long hold-off plus a sender gap.
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int RANDOM_PHASES    = 8;
    localparam int MAX_GAP          = 12;
    localparam int MAX_BURST        = 40;

    // Register index past the end of the register file; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int unsigned {
        READY_ALWAYS,
        READY_COIN,
        READY_EVERY_THIRD,
        READY_SPARSE
    } t_stall_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [COUNT_W-1:0]    i_active_count = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [RATE_W-1:0]     o_max_rate_hz;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int          check_errors;
    int          outstanding;
    int          stall_cycles = 0;
    int unsigned burst_left = 0;
    bit          hold_off_req = 1'b0;
    bit          hold_off_done = 1'b0;

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    adc_scan_rate_limit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_active_count (i_active_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_max_rate_hz  (o_max_rate_hz),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    rate_limit_checker scan_rate_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_active_count (i_active_count),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_max_rate_hz  (o_max_rate_hz),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (check_errors),
        .o_outstanding  (outstanding)
    );

    // Offer one scan count. Beats go out in bursts; when a burst runs out the
    // sender drops valid for a random gap before the next one starts. Valid
    // is only lowered in a gap or by drain_results, so it never falls and rises in the same step.
    task automatic send_count(input logic [COUNT_W-1:0] count);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
            burst_left = $urandom_range(1, MAX_BURST);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_active_count <= count;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop offering and wait until every predicted rate has come back. The
    // first edge lets the checker account for a beat taken at this step.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Write enable is left high between back-to-back writes; the caller lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Timing registers change only with the pipeline empty. Data is always the
    // full port width, so values too wide for a register exercise its masking.
    task automatic program_timing(input logic [CFG_DATA_W-1:0] clk_div,
                                  input logic [CFG_DATA_W-1:0] adc_div,
                                  input logic [CFG_DATA_W-1:0] sample,
                                  input bit poke_unused);
        drain_results();
        write_reg(CFG_CLK_DIV, clk_div);
        write_reg(CFG_ADC_DIV, adc_div);
        write_reg(CFG_SAMPLE, sample);
        if (poke_unused)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Small values keep the rate away from the floor, and half of the picks are small,
    // so many random settings land in the interesting middle of the division.
    function automatic logic [CFG_DATA_W-1:0] pick_reg_data(input int unsigned small_max);
        int unsigned pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else if (pick == 5)
            return CFG_DATA_W'($urandom);
        else
            return CFG_DATA_W'($urandom_range(1, small_max));
    endfunction

    // The receiver runs its own stall pattern in random spans: always ready,
    // coin flip, periodically ready and mostly stalled. Once, on request, it
    // holds off long enough for the pipeline to fill and stall the input.
    initial begin : out_stall_pattern
        t_stall_mode mode;
        int unsigned span;
        forever begin
            if (hold_off_req && !hold_off_done) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end else begin
                mode = t_stall_mode'($urandom_range(0, 3));
                span = $urandom_range(8, 64);
                for (int unsigned k = 0; k < span; k++) begin
                    case (mode)
                        READY_ALWAYS:      i_out_ready <= 1'b1;
                        READY_COIN:        i_out_ready <= 1'($urandom_range(0, 1));
                        READY_EVERY_THIRD: i_out_ready <= (k % 3 == 0);
                        default:           i_out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // The watchdog ends a run that stops moving: a cycle counts as quiet when
    // no beat is taken on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned phase_items;
        logic [COUNT_W-1:0] count;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timing: no scan armed, the shortest and longest legal lists,
        // counts past 64, and alternating bit patterns.
        send_count(7'd0);
        send_count(7'd1);
        send_count(7'd64);
        send_count(7'd65);
        send_count(7'd127);
        send_count(7'h55);
        send_count(7'h2A);

        // Fastest timing with the reserved ADC divider: even the longest scans hit the cap.
        program_timing('0, '0, '0, 1'b0);
        send_count(7'd1);
        send_count(7'd127);
        send_count(7'd0);

        // Every register at full port width: masked to the slowest timing, and
        // long scans fall to the one hertz floor. The dropped index is poked too.
        program_timing('1, '1, '1, 1'b1);
        send_count(7'd1);
        send_count(7'd64);
        send_count(7'd127);

        // A middle setting: a short scan still hits the cap, a longer one is set by the division alone.
        program_timing(10'd1, 10'd2, 10'd200, 1'b0);
        send_count(7'd3);
        send_count(7'd40);

        // Random phases. Each one picks new timing, then sends mostly legal
        // list lengths with some out-of-range ones. The second phase also asks
        // the receiver for its long hold-off while the sender keeps offering.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            program_timing(pick_reg_data(8), pick_reg_data(8), pick_reg_data(64),
                           ($urandom_range(0, 2) == 0));
            if (phase == 1)
                hold_off_req = 1'b1;
            phase_items = $urandom_range(150, 270);
            repeat (phase_items) begin
                if ($urandom_range(0, 4) == 0)
                    count = COUNT_W'($urandom_range(65, 127));
                else
                    count = COUNT_W'($urandom_range(0, 64));
                send_count(count);
            end
        end

        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (check_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/asrl_pkg.sv
rtl/asrl_front.sv
rtl/asrl_div_cell.sv
rtl/adc_scan_rate_limit.sv
dv/rate_limit_checker.sv
dv/testbench.sv
